FILE: rtl/rmq_pkg.sv
// rmq_pkg: widths, stage records and the saturation helper for the
// rotation-matrix-to-quaternion pipeline. No dependencies.
package rmq_pkg;

  // element format
  localparam int DATA_W = 16;
  localparam int FRAC_W = 14;
  // sum or difference of two elements
  localparam int NUM_W  = DATA_W + 1;
  // signed radicand (one plus three elements)
  localparam int R_W    = DATA_W + 3;
  // square root: radicand scaled by one, result bits, partial remainder
  localparam int ROOT_W = DATA_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 3;
  // divider: divisor 2h, scaled dividend, quotient bits, remainder
  localparam int DIVS_W = ROOT_W + 1;
  localparam int DVD_W  = NUM_W + FRAC_W;
  localparam int QUO_W  = DATA_W + 8;
  localparam int DREM_W = DIVS_W + 1;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  localparam logic [R_W-1:0] ONE_R = R_W'(1) << FRAC_W;

  // record that travels with the square root
  typedef struct packed {
    logic                  valid;
    logic [1:0]            branch;
    logic                  degen;
    logic [3:0][NUM_W-1:0] num;
  } sq_side_t;

  // record that travels with the dividers
  typedef struct packed {
    logic              valid;
    logic [1:0]        branch;
    logic              degen;
    logic [ROOT_W-1:0] root;
    logic [3:0]        neg;
  } dv_side_t;

  // signed saturation of a magnitude and a sign to the element format
  function automatic logic [DATA_W-1:0] sat_mag(input logic [QUO_W-1:0] mag,
                                                 input logic neg);
    logic [QUO_W-1:0]  pos_max;
    logic [QUO_W-1:0]  negv;
    logic [DATA_W-1:0] res;
    pos_max = (QUO_W'(1) << (DATA_W - 1)) - QUO_W'(1);
    negv    = -mag;
    if (!neg) begin
      res = (mag > pos_max) ? pos_max[DATA_W-1:0] : mag[DATA_W-1:0];
    end else begin
      res = (mag > pos_max + QUO_W'(1)) ? {1'b1, {(DATA_W-1){1'b0}}} : negv[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/rmq_sqrt.sv
// rmq_sqrt: pipelined integer square root, one result bit per stage.
// Depends on rmq_pkg.
module rmq_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rmq_pkg::sq_side_t               side_in,
  input  logic [rmq_pkg::RAD_W-1:0]       rad_in,
  output rmq_pkg::sq_side_t               side_out,
  output logic [rmq_pkg::ROOT_W-1:0]      root_out
);
  import rmq_pkg::*;

  sq_side_t          sd_r   [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [SREM_W-1:0] rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_st
    sq_side_t          sd_in;
    logic [RAD_W-1:0]  rad_cur;
    logic [SREM_W-1:0] rem_cur;
    logic [ROOT_W-1:0] root_cur;
    logic [SREM_W-1:0] rem_sh;
    logic [SREM_W-1:0] trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign sd_in    = side_in;
      assign rad_cur  = rad_in;
      assign rem_cur  = '0;
      assign root_cur = '0;
    end else begin : g_next
      assign sd_in    = sd_r[i-1];
      assign rad_cur  = rad_r[i-1];
      assign rem_cur  = rem_r[i-1];
      assign root_cur = root_r[i-1];
    end

    // bring down two radicand bits and try root*4+1
    assign rem_sh = {rem_cur[SREM_W-3:0], rad_cur[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_cur, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[i].valid <= 1'b0;
      end else begin
        sd_r[i].valid <= sd_in.valid;
      end
      sd_r[i].branch <= sd_in.branch;
      sd_r[i].degen  <= sd_in.degen;
      sd_r[i].num    <= sd_in.num;
      rad_r[i]       <= rad_cur << 2;
      rem_r[i]       <= ge ? rem_sh - trial : rem_sh;
      root_r[i]      <= {root_cur[ROOT_W-2:0], ge};
    end
  end

  assign side_out = sd_r[ROOT_W-1];
  assign root_out = root_r[ROOT_W-1];

endmodule

FILE: rtl/rmq_div.sv
// rmq_div: four-lane pipelined restoring divider, one quotient bit per stage.
// Computes round(|num| * one / 2h) per lane. Depends on rmq_pkg.
module rmq_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rmq_pkg::sq_side_t                  side_in,
  input  logic [rmq_pkg::ROOT_W-1:0]         root_in,
  output rmq_pkg::dv_side_t                  side_out,
  output logic [3:0][rmq_pkg::QUO_W-1:0]     quo_out
);
  import rmq_pkg::*;

  dv_side_t          init_side;
  logic [DIVS_W-1:0] init_div;
  logic [3:0][DREM_W-1:0] init_rem;
  logic [3:0][QUO_W-1:0]  init_low;

  dv_side_t               sd_r  [QUO_W];
  logic [DIVS_W-1:0]      div_r [QUO_W];
  logic [3:0][DREM_W-1:0] rem_r [QUO_W];
  logic [3:0][QUO_W-1:0]  low_r [QUO_W];

  // lane setup: magnitude, scaled dividend plus half divisor
  always_comb begin
    logic [NUM_W-1:0] mag;
    logic [DVD_W-1:0] dvd;
    init_side.valid  = side_in.valid;
    init_side.branch = side_in.branch;
    init_side.degen  = side_in.degen;
    init_side.root   = root_in;
    init_div         = {root_in, 1'b0};
    for (int k = 0; k < 4; k++) begin
      init_side.neg[k] = side_in.num[k][NUM_W-1];
      mag = side_in.num[k][NUM_W-1] ? -side_in.num[k] : side_in.num[k];
      dvd = {mag, {FRAC_W{1'b0}}} + DVD_W'(root_in);
      init_rem[k] = DREM_W'(dvd[DVD_W-1:QUO_W]);
      init_low[k] = dvd[QUO_W-1:0];
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_st
    dv_side_t               sd_in;
    logic [DIVS_W-1:0]      div_cur;
    logic [3:0][DREM_W-1:0] rem_cur;
    logic [3:0][QUO_W-1:0]  low_cur;
    logic [3:0][DREM_W-1:0] rem_nxt;
    logic [3:0][QUO_W-1:0]  low_nxt;

    if (i == 0) begin : g_first
      assign sd_in   = init_side;
      assign div_cur = init_div;
      assign rem_cur = init_rem;
      assign low_cur = init_low;
    end else begin : g_next
      assign sd_in   = sd_r[i-1];
      assign div_cur = div_r[i-1];
      assign rem_cur = rem_r[i-1];
      assign low_cur = low_r[i-1];
    end

    // shift in next dividend bit, subtract when it fits
    always_comb begin
      logic [DREM_W-1:0] sh;
      logic              ge;
      for (int k = 0; k < 4; k++) begin
        sh = {rem_cur[k][DREM_W-2:0], low_cur[k][QUO_W-1]};
        ge = (sh >= {1'b0, div_cur});
        rem_nxt[k] = ge ? sh - {1'b0, div_cur} : sh;
        low_nxt[k] = {low_cur[k][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[i].valid <= 1'b0;
      end else begin
        sd_r[i].valid <= sd_in.valid;
      end
      sd_r[i].branch <= sd_in.branch;
      sd_r[i].degen  <= sd_in.degen;
      sd_r[i].root   <= sd_in.root;
      sd_r[i].neg    <= sd_in.neg;
      div_r[i]       <= div_cur;
      rem_r[i]       <= rem_nxt;
      low_r[i]       <= low_nxt;
    end
  end

  assign side_out = sd_r[QUO_W-1];
  assign quo_out  = low_r[QUO_W-1];

endmodule

FILE: rtl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to unit quaternion, four-branch trace method.
// Fully pipelined: a new matrix may be started every cycle and busy is never
// raised. Each result appears with out_valid high for one cycle, once its start
// transfer has passed a branch selection register, 16 stages of square
// root (one root bit per stage), 24 stages of division (one quotient bit per
// stage, four lanes in parallel) and an output register. The receiver cannot
// stall; results are never held. Depends on rmq_pkg, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m00,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m01,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m02,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m10,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m11,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m12,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m20,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m21,
  input  logic signed [rmq_pkg::DATA_W-1:0]  in_m22,
  output logic                               out_valid,
  output logic signed [rmq_pkg::DATA_W-1:0]  out_quat_w,
  output logic signed [rmq_pkg::DATA_W-1:0]  out_quat_x,
  output logic signed [rmq_pkg::DATA_W-1:0]  out_quat_y,
  output logic signed [rmq_pkg::DATA_W-1:0]  out_quat_z,
  output logic [1:0]                         out_branch_used,
  output logic                               out_degenerate
);
  import rmq_pkg::*;

  logic signed [R_W-1:0]   d00, d11, d22, trace;
  logic [1:0]              branch_nxt;
  logic signed [R_W-1:0]   rad_nxt;
  logic [3:0][NUM_W-1:0]   num_nxt;

  logic                    fr_valid_r;
  logic [1:0]              fr_branch_r;
  logic signed [R_W-1:0]   fr_rad_r;
  logic [3:0][NUM_W-1:0]   fr_num_r;

  sq_side_t                sq_in;
  logic [RAD_W-1:0]        sq_rad;
  sq_side_t                sq_out;
  logic [ROOT_W-1:0]       sq_root;
  dv_side_t                dv_out;
  logic [3:0][QUO_W-1:0]   dv_quo;
  logic [3:0][DATA_W-1:0]  comp;

  logic                    out_valid_r;
  logic [3:0][DATA_W-1:0]  out_q_r;
  logic [1:0]              out_br_r;
  logic                    out_dg_r;

  assign busy = 1'b0;

  // branch choice, radicand and the four numerators
  always_comb begin
    logic signed [NUM_W-1:0] a, b, c;
    d00   = R_W'(in_m00);
    d11   = R_W'(in_m11);
    d22   = R_W'(in_m22);
    trace = d00 + d11 + d22;
    a = NUM_W'(in_m21) - NUM_W'(in_m12);
    b = NUM_W'(in_m02) - NUM_W'(in_m20);
    c = NUM_W'(in_m10) - NUM_W'(in_m01);
    if (trace > 0) begin
      branch_nxt = BR_TRACE;
      rad_nxt    = trace + ONE_R;
      num_nxt    = {c, b, a, {NUM_W{1'b0}}};
    end else if (in_m00 > in_m11 && in_m00 > in_m22) begin
      branch_nxt = BR_X;
      rad_nxt    = ONE_R + d00 - d11 - d22;
      num_nxt    = {NUM_W'(in_m02) + NUM_W'(in_m20), NUM_W'(in_m01) + NUM_W'(in_m10),
                    {NUM_W{1'b0}}, a};
    end else if (in_m11 > in_m22) begin
      branch_nxt = BR_Y;
      rad_nxt    = ONE_R + d11 - d00 - d22;
      num_nxt    = {NUM_W'(in_m12) + NUM_W'(in_m21), {NUM_W{1'b0}},
                    NUM_W'(in_m01) + NUM_W'(in_m10), b};
    end else begin
      branch_nxt = BR_Z;
      rad_nxt    = ONE_R + d22 - d00 - d11;
      num_nxt    = {{NUM_W{1'b0}}, NUM_W'(in_m12) + NUM_W'(in_m21),
                    NUM_W'(in_m02) + NUM_W'(in_m20), c};
    end
  end

  // front register, loaded on each start transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= start && !busy;
    end
    fr_branch_r <= branch_nxt;
    fr_rad_r    <= rad_nxt;
    fr_num_r    <= num_nxt;
  end

  // degenerate check and radicand scaled by one
  always_comb begin
    sq_in.valid  = fr_valid_r;
    sq_in.branch = fr_branch_r;
    sq_in.degen  = (fr_rad_r <= 0);
    sq_in.num    = fr_num_r;
    sq_rad       = sq_in.degen ? '0 : {fr_rad_r[RAD_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
  end

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_in  (sq_in),
    .rad_in   (sq_rad),
    .side_out (sq_out),
    .root_out (sq_root)
  );

  rmq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_in  (sq_out),
    .root_in  (sq_root),
    .side_out (dv_out),
    .quo_out  (dv_quo)
  );

  // chosen component from the root, others from the quotients, saturated; all zero if degenerate
  always_comb begin
    logic [ROOT_W:0] half;
    half = ({1'b0, dv_out.root} + (ROOT_W+1)'(1)) >> 1;
    for (int k = 0; k < 4; k++) begin
      if (dv_out.degen) begin
        comp[k] = '0;
      end else if (dv_out.branch == 2'(k)) begin
        comp[k] = sat_mag(QUO_W'(half), 1'b0);
      end else begin
        comp[k] = sat_mag(dv_quo[k], dv_out.neg[k]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_out.valid;
    end
    out_q_r  <= comp;
    out_br_r <= dv_out.branch;
    out_dg_r <= dv_out.degen;
  end

  assign out_valid       = out_valid_r;
  assign out_quat_w      = out_q_r[0];
  assign out_quat_x      = out_q_r[1];
  assign out_quat_y      = out_q_r[2];
  assign out_quat_z      = out_q_r[3];
  assign out_branch_used = out_br_r;
  assign out_degenerate  = out_dg_r;

endmodule
